FILE: rtl/cmpg_pkg.sv
// cmpg_pkg: widths, register codes and shared types of the circle moire pixel generator
// no dependencies; used by the interfaces, the divider and the top level
package cmpg_pkg;

    localparam int COORD_W      = 10;
    localparam int OFS_W        = 10;
    localparam int SCALE_W      = 9;
    localparam int COLOR_W      = 24;
    localparam int CHAN_W       = 8;
    localparam int CHANNELS     = COLOR_W / CHAN_W;
    localparam int PALETTE_SIZE = 256;
    localparam int IDX_W        = $clog2(PALETTE_SIZE);
    localparam int SUM_W        = COORD_W + 2;
    localparam int ABS_W        = SUM_W - 1;
    localparam int SQ_W         = 2 * ABS_W;
    localparam int NUM_W        = SQ_W + 4;
    localparam int DIV_BITS     = 2;
    localparam int DIV_STAGES   = NUM_W / DIV_BITS;
    localparam int PROD_W       = 2 * CHAN_W + 3;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;

    localparam logic [SCALE_W-1:0] SCALE_RST = 9'd1;
    localparam logic [COLOR_W-1:0] START_RST = 24'h000000;
    localparam logic [COLOR_W-1:0] END_RST   = 24'hFFFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_OFFSET     = 3'd0,
        CFG_Y_OFFSET     = 3'd1,
        CFG_SCALE_FACTOR = 3'd2,
        CFG_START_COLOR  = 3'd3,
        CFG_END_COLOR    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic             vld;
        logic [NUM_W-1:0] num;
    } t_div_in;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] quo;
    } t_div_out;

endpackage

FILE: rtl/cmpg_if.sv
// cmpg_if: valid/ready channel interfaces for pixel input, color output and config writes
// depends on cmpg_pkg for field widths
interface cmpg_pix_if;
    logic                         valid;
    logic                         ready;
    logic [cmpg_pkg::COORD_W-1:0] column;
    logic [cmpg_pkg::COORD_W-1:0] row;

    modport source (output valid, output column, output row, input ready);
    modport sink   (input valid, input column, input row, output ready);
endinterface

interface cmpg_color_if;
    logic                         valid;
    logic                         ready;
    logic [cmpg_pkg::COLOR_W-1:0] pixel_color;
    logic [cmpg_pkg::IDX_W-1:0]   palette_index;

    modport source (output valid, output pixel_color, output palette_index, input ready);
    modport sink   (input valid, input pixel_color, input palette_index, output ready);
endinterface

interface cmpg_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cmpg_pkg::CFG_IDX_W-1:0]  index;
    logic [cmpg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/cmpg_div.sv
// cmpg_div: pipelined restoring divider, two quotient bits per stage, keeps the low quotient byte
// depends on cmpg_pkg for widths and the request and response structs
module cmpg_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [cmpg_pkg::SCALE_W-1:0] i_divisor,
    input  cmpg_pkg::t_div_in            i_req,
    output cmpg_pkg::t_div_out           o_rsp
);
    localparam int NW = cmpg_pkg::NUM_W;
    localparam int DW = cmpg_pkg::SCALE_W;
    localparam int QW = cmpg_pkg::IDX_W;
    localparam int NS = cmpg_pkg::DIV_STAGES;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NW-1:0] r_num [NS];
    logic [NW-1:0] n_num [NS];
    logic [DW-1:0] r_rem [NS];
    logic [DW-1:0] n_rem [NS];
    logic [QW-1:0] r_quo [NS];
    logic [QW-1:0] n_quo [NS];
    logic [DW-1:0] w_div;

    // zero scale acts as one
    assign w_div = (i_divisor == '0) ? DW'(1) : i_divisor;
    assign n_vld = {r_vld[NS-2:0], i_req.vld};

    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic [NW-1:0] w_num_src;
        logic [DW-1:0] w_rem_src;
        logic [QW-1:0] w_quo_src;

        if (g == 0) begin : g_first
            assign w_num_src = i_req.num;
            assign w_rem_src = '0;
            assign w_quo_src = '0;
        end else begin : g_next
            assign w_num_src = r_num[g-1];
            assign w_rem_src = r_rem[g-1];
            assign w_quo_src = r_quo[g-1];
        end

        always_comb begin
            logic [NW-1:0] v_num;
            logic [DW-1:0] v_rem;
            logic [QW-1:0] v_quo;
            logic [DW:0]   v_trial;
            v_num = w_num_src;
            v_rem = w_rem_src;
            v_quo = w_quo_src;
            for (int k = 0; k < cmpg_pkg::DIV_BITS; k++) begin
                v_trial = {v_rem, v_num[NW-1]};
                v_num   = {v_num[NW-2:0], 1'b0};
                if (v_trial >= {1'b0, w_div}) begin
                    v_trial = v_trial - {1'b0, w_div};
                    v_quo   = {v_quo[QW-2:0], 1'b1};
                end else begin
                    v_quo   = {v_quo[QW-2:0], 1'b0};
                end
                v_rem = v_trial[DW-1:0];
            end
            n_num[g] = v_num;
            n_rem[g] = v_rem;
            n_quo[g] = v_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.vld = r_vld[NS-1];
    assign o_rsp.quo = r_quo[NS-1];

endmodule

FILE: rtl/circle_moire_pixel_generator_unit.sv
// circle_moire_pixel_generator_unit: top level, config registers, squaring, divider and blend
// depends on cmpg_pkg, the cmpg interfaces and cmpg_div
//
// channel   modport  payload                        transaction
// i_pix     sink     column, row                    valid && ready
// o_color   source   pixel_color, palette_index     valid && ready
// i_cfg     sink     index, data                    valid (ready tied high)
//
// one pixel enters per cycle unless the pipeline holds; stages in order: offset, square and scale,
// then the divider (two quotient bits a stage), then the product and color registers of the gradient blend
// the whole pipeline holds while a result waits on o_color; i_pix.ready follows that hold
// synchronous active-low reset clears valid bits and loads the register reset values
module circle_moire_pixel_generator_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cmpg_pix_if.sink             i_pix,
    cmpg_color_if.source         o_color,
    cmpg_cfg_if.sink             i_cfg
);
    localparam int SW  = cmpg_pkg::SUM_W;
    localparam int AW  = cmpg_pkg::ABS_W;
    localparam int QW  = cmpg_pkg::SQ_W;
    localparam int NW  = cmpg_pkg::NUM_W;
    localparam int HW  = cmpg_pkg::CHAN_W;
    localparam int PW  = cmpg_pkg::PROD_W;
    localparam int NCH = cmpg_pkg::CHANNELS;
    localparam int IW  = cmpg_pkg::IDX_W;

    logic [cmpg_pkg::OFS_W-1:0]   r_x_ofs;
    logic [cmpg_pkg::OFS_W-1:0]   r_y_ofs;
    logic [cmpg_pkg::SCALE_W-1:0] r_scale;
    logic [cmpg_pkg::COLOR_W-1:0] r_start;
    logic [cmpg_pkg::COLOR_W-1:0] r_end;

    logic w_en;
    logic w_in_acc;

    logic [2:0]  r_vld_f;
    logic [AW-1:0] r_ax;
    logic [AW-1:0] r_ay;
    logic [QW-1:0] r_sqx;
    logic [QW-1:0] r_sqy;
    logic [NW-1:0] r_num;

    logic [SW-1:0] w_dx;
    logic [SW-1:0] w_dy;
    logic [SW-1:0] w_ax;
    logic [SW-1:0] w_ay;
    logic [QW:0]   w_sum;
    logic [NW-1:0] w_sum_ext;

    cmpg_pkg::t_div_in  w_div_req;
    cmpg_pkg::t_div_out w_div_rsp;

    logic                 r_vld_a;
    logic [IW-1:0]        r_idx_a;
    logic signed [PW-1:0] r_prod [NCH];
    logic signed [PW-1:0] n_prod [NCH];

    logic                         r_out_vld;
    logic [IW-1:0]                r_out_idx;
    logic [cmpg_pkg::COLOR_W-1:0] r_out_color;
    logic [cmpg_pkg::COLOR_W-1:0] n_out_color;

    // config writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_ofs <= '0;
            r_y_ofs <= '0;
            r_scale <= cmpg_pkg::SCALE_RST;
            r_start <= cmpg_pkg::START_RST;
            r_end   <= cmpg_pkg::END_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                cmpg_pkg::CFG_X_OFFSET:     r_x_ofs <= i_cfg.data[cmpg_pkg::OFS_W-1:0];
                cmpg_pkg::CFG_Y_OFFSET:     r_y_ofs <= i_cfg.data[cmpg_pkg::OFS_W-1:0];
                cmpg_pkg::CFG_SCALE_FACTOR: r_scale <= i_cfg.data[cmpg_pkg::SCALE_W-1:0];
                cmpg_pkg::CFG_START_COLOR:  r_start <= i_cfg.data[cmpg_pkg::COLOR_W-1:0];
                cmpg_pkg::CFG_END_COLOR:    r_end   <= i_cfg.data[cmpg_pkg::COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // global pipeline hold
    assign w_en        = !r_out_vld || o_color.ready;
    assign i_pix.ready = w_en;
    assign w_in_acc    = i_pix.valid && w_en;

    // offset and magnitude
    assign w_dx = {2'b00, i_pix.column} + {{(SW-cmpg_pkg::OFS_W){r_x_ofs[cmpg_pkg::OFS_W-1]}},
                                           r_x_ofs};
    assign w_dy = {2'b00, i_pix.row} + {{(SW-cmpg_pkg::OFS_W){r_y_ofs[cmpg_pkg::OFS_W-1]}},
                                        r_y_ofs};
    assign w_ax = w_dx[SW-1] ? (SW'(0) - w_dx) : w_dx;
    assign w_ay = w_dy[SW-1] ? (SW'(0) - w_dy) : w_dy;

    // ten times the sum of squares
    assign w_sum     = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign w_sum_ext = NW'(w_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_f <= '0;
        end else if (w_en) begin
            r_vld_f <= {r_vld_f[1:0], w_in_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ax  <= w_ax[AW-1:0];
            r_ay  <= w_ay[AW-1:0];
            r_sqx <= QW'(r_ax) * QW'(r_ax);
            r_sqy <= QW'(r_ay) * QW'(r_ay);
            r_num <= (w_sum_ext << 3) + (w_sum_ext << 1);
        end
    end

    assign w_div_req.vld = r_vld_f[2];
    assign w_div_req.num = r_num;

    cmpg_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_divisor (r_scale),
        .i_req     (w_div_req),
        .o_rsp     (w_div_rsp)
    );

    // gradient: (end - start) * (index + 1) per channel
    always_comb begin
        logic [HW:0] v_diff;
        logic [IW:0] v_step;
        v_step = {1'b0, w_div_rsp.quo} + (IW+1)'(1);
        for (int c = 0; c < NCH; c++) begin
            v_diff    = {1'b0, r_end[c*HW +: HW]} - {1'b0, r_start[c*HW +: HW]};
            n_prod[c] = PW'($signed(v_diff) * $signed({1'b0, v_step}));
        end
    end

    // divide by palette size toward zero, add start
    always_comb begin
        logic [PW-1:0] v_adj;
        for (int c = 0; c < NCH; c++) begin
            v_adj = r_prod[c] + PW'({HW{r_prod[c][PW-1]}});
            n_out_color[c*HW +: HW] = r_start[c*HW +: HW] + v_adj[2*HW-1:HW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld_a   <= w_div_rsp.vld;
            r_out_vld <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_idx_a     <= w_div_rsp.quo;
            r_prod      <= n_prod;
            r_out_idx   <= r_idx_a;
            r_out_color <= n_out_color;
        end
    end

    assign o_color.valid         = r_out_vld;
    assign o_color.pixel_color   = r_out_color;
    assign o_color.palette_index = r_out_idx;

    // a hold freezes every valid bit of the top-level stages
    a_hold_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable({r_vld_f, r_vld_a, r_out_vld}))
        else $error("pipeline valid bits moved during a hold");

    // reset empties the output stage and clears the front-end valid bits
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_color.valid && r_vld_f == '0)
        else $error("valid bits set after reset");

endmodule

FILE: sim/circle_moire_pixel_checker.sv
`timescale 1ns / 1ps
// circle_moire_pixel_checker: watches the pixel, color and register channels, predicts the
// ring index and gradient color of every pixel and compares them in arrival order
// depends on cmpg_pkg and the cmpg channel interfaces
module circle_moire_pixel_checker
    import cmpg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    cmpg_pix_if   i_pix,
    cmpg_color_if i_color,
    cmpg_cfg_if   i_cfg,
    output int    o_pending,
    output int    o_failures
);

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic [IDX_W-1:0]   palette_index;
    } t_pixel_color;

    logic signed [OFS_W-1:0] x_ofs;
    logic signed [OFS_W-1:0] y_ofs;
    logic [SCALE_W-1:0]      scale;
    logic [COLOR_W-1:0]      start_c;
    logic [COLOR_W-1:0]      end_c;

    t_pixel_color expected_pixels[$];
    int           failures = 0;

    assign o_failures = failures;

    function automatic t_pixel_color shade_pixel(input logic [COORD_W-1:0] col,
                                                 input logic [COORD_W-1:0] rw);
        int           dx;
        int           dy;
        int           divisor;
        int           ring_quot;
        int           step;
        int           lo;
        int           hi;
        int           mix;
        t_pixel_color res;
        dx = int'(col) + int'(x_ofs);
        dy = int'(rw) + int'(y_ofs);
        divisor = (scale == '0) ? 1 : int'(scale);
        ring_quot = (dx * dx + dy * dy) * 10 / divisor;
        res.palette_index = ring_quot[IDX_W-1:0];
        step = int'(res.palette_index) + 1;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            lo = int'(start_c[ch*CHAN_W +: CHAN_W]);
            hi = int'(end_c[ch*CHAN_W +: CHAN_W]);
            mix = lo + (hi - lo) * step / PALETTE_SIZE;
            res.pixel_color[ch*CHAN_W +: CHAN_W] = mix[CHAN_W-1:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_pixel_color want;
        if (!i_rst_n) begin
            x_ofs   <= '0;
            y_ofs   <= '0;
            scale   <= SCALE_RST;
            start_c <= START_RST;
            end_c   <= END_RST;
            expected_pixels.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_X_OFFSET:     x_ofs   <= i_cfg.data[OFS_W-1:0];
                    CFG_Y_OFFSET:     y_ofs   <= i_cfg.data[OFS_W-1:0];
                    CFG_SCALE_FACTOR: scale   <= i_cfg.data[SCALE_W-1:0];
                    CFG_START_COLOR:  start_c <= i_cfg.data[COLOR_W-1:0];
                    CFG_END_COLOR:    end_c   <= i_cfg.data[COLOR_W-1:0];
                    default: ;
                endcase
            end
            if (i_color.valid && i_color.ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected color transaction, pixel_color %06h palette_index %0d",
                             $time, i_color.pixel_color, i_color.palette_index);
                    failures++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_color.pixel_color !== want.pixel_color) begin
                        $display("%0t: pixel_color expected %06h actual %06h",
                                 $time, want.pixel_color, i_color.pixel_color);
                        failures++;
                    end
                    if (i_color.palette_index !== want.palette_index) begin
                        $display("%0t: palette_index expected %0d actual %0d",
                                 $time, want.palette_index, i_color.palette_index);
                        failures++;
                    end
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                expected_pixels.push_back(shade_pixel(i_pix.column, i_pix.row));
            end
        end
        o_pending <= expected_pixels.size();
    end

endmodule

FILE: sim/circle_moire_pixel_generator_unit_test.sv
`timescale 1ns / 1ps
// circle_moire_pixel_generator_unit_test: clock, reset, register settings and pixel stimulus
// with random stalls on both channels; depends on cmpg_pkg, the cmpg interfaces, the block
// and circle_moire_pixel_checker, which predicts and compares
module circle_moire_pixel_generator_unit_test;
    import cmpg_pkg::*;

    localparam int FRAME_SIZE   = 512;
    localparam int RANDOM_ITEMS = 1930;
    localparam int SETTLE_CYCLES = 40;

    logic i_clk;
    logic i_rst_n;
    int   pending;
    int   failures;
    int   pixel_count = 0;
    int   write_count = 0;
    int   setting_count = 1;
    bit   quiet_mode = 1'b0;

    cmpg_pix_if   pix_if();
    cmpg_color_if color_if();
    cmpg_cfg_if   cfg_if();

    circle_moire_pixel_generator_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_color (color_if),
        .i_cfg   (cfg_if)
    );

    circle_moire_pixel_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .i_color    (color_if),
        .i_cfg      (cfg_if),
        .o_pending  (pending),
        .o_failures (failures)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_offset();
        int                    r;
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom());
        r = $urandom_range(0, 9);
        if (r < 5) d[OFS_W-1:0] = OFS_W'(int'($urandom_range(0, 511)) - 255);
        else if (r == 5) d[OFS_W-1:0] = {1'b1, {(OFS_W-1){1'b0}}};
        else if (r == 6) d[OFS_W-1:0] = {1'b0, {(OFS_W-1){1'b1}}};
        else if (r == 7) d[OFS_W-1:0] = '0;
        return d;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_scale();
        int                    r;
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom());
        r = $urandom_range(0, 9);
        if (r < 6) d[SCALE_W-1:0] = SCALE_W'($urandom_range(1, 300));
        else if (r == 6) d[SCALE_W-1:0] = '0;
        else if (r == 7) d[SCALE_W-1:0] = '1;
        else if (r == 8) d[SCALE_W-1:0] = SCALE_W'($urandom_range(1, 4));
        return d;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_color();
        int r;
        r = $urandom_range(0, 9);
        if (r == 8) return '0;
        if (r == 9) return '1;
        return CFG_DATA_W'($urandom());
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        bit taken;
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = cfg_if.ready;
            @(posedge i_clk);
        end
        cfg_if.valid <= 1'b0;
        write_count++;
        @(posedge i_clk);
    endtask

    task automatic write_unused_reg();
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_END_COLOR) + 1, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom()));
    endtask

    task automatic set_all(input logic [CFG_DATA_W-1:0] x_ofs,
                           input logic [CFG_DATA_W-1:0] y_ofs,
                           input logic [CFG_DATA_W-1:0] scale,
                           input logic [CFG_DATA_W-1:0] start_c,
                           input logic [CFG_DATA_W-1:0] end_c);
        write_reg(CFG_X_OFFSET, x_ofs);
        write_reg(CFG_Y_OFFSET, y_ofs);
        write_reg(CFG_SCALE_FACTOR, scale);
        write_reg(CFG_START_COLOR, start_c);
        write_reg(CFG_END_COLOR, end_c);
        setting_count++;
    endtask

    task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] rw);
        bit taken;
        int gap;
        pix_if.valid  <= 1'b1;
        pix_if.column <= col;
        pix_if.row    <= rw;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = pix_if.ready;
            @(posedge i_clk);
        end
        pixel_count++;
        gap = pick_gap();
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_pixels();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : color_sink
        int gap;
        color_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            color_if.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                color_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int random_count;
        int n;
        pix_if.valid  <= 1'b0;
        pix_if.column <= '0;
        pix_if.row    <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= '0;
        cfg_if.data   <= '0;
        i_rst_n       <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, frame corners and coordinates outside the frame
        send_pixel(1, 1);
        send_pixel(512, 512);
        send_pixel(0, 0);
        send_pixel('1, '1);
        send_pixel(1, 512);
        drain_pixels();

        // most negative and most positive offsets, zero scale, falling gradient
        set_all(CFG_DATA_W'(-512), CFG_DATA_W'(511), '0, '1, '0);
        write_unused_reg();
        write_unused_reg();
        send_pixel(0, 0);
        send_pixel('1, 0);
        send_pixel(0, '1);
        send_pixel('1, '1);
        send_pixel(512, 1);
        drain_pixels();

        set_all(CFG_DATA_W'(256), CFG_DATA_W'(-255), 24'hFFF12C, 24'h123456, 24'hEDCBA9);
        send_pixel(1, 1);
        send_pixel(512, 512);
        send_pixel(256, 300);
        drain_pixels();

        set_all('0, '0, 24'h0001FF, '0, '1);
        send_pixel('1, '1);
        send_pixel(1, 1);
        drain_pixels();

        set_all('0, '0, 24'h000001, 24'h00FF00, 24'hFF00FF);
        send_pixel(1, 1);
        send_pixel(16, 0);
        send_pixel(100, 37);
        drain_pixels();

        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 7) write_reg(CFG_X_OFFSET, pick_offset());
            if ($urandom_range(0, 9) < 7) write_reg(CFG_Y_OFFSET, pick_offset());
            if ($urandom_range(0, 9) < 7) write_reg(CFG_SCALE_FACTOR, pick_scale());
            if ($urandom_range(0, 9) < 7) write_reg(CFG_START_COLOR, pick_color());
            if ($urandom_range(0, 9) < 7) write_reg(CFG_END_COLOR, pick_color());
            if ($urandom_range(0, 4) == 0) write_unused_reg();
            setting_count++;
            quiet_mode = ($urandom_range(0, 3) == 0);
            n = $urandom_range(60, 180);
            if (n > RANDOM_ITEMS - random_count) n = RANDOM_ITEMS - random_count;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) < 8)
                    send_pixel(COORD_W'($urandom()), COORD_W'($urandom()));
                else
                    send_pixel(COORD_W'($urandom_range(1, FRAME_SIZE)),
                               COORD_W'($urandom_range(1, FRAME_SIZE)));
                random_count++;
            end
            drain_pixels();
            quiet_mode = 1'b0;
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d pixel transactions under %0d register settings",
                 pixel_count, setting_count);
        $display("%0d register write transactions, unused indexes included", write_count);
        if (failures == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
